[rtl/ray_cone_intersection_macros.svh]
// Assertion macros used by the checker file of the ray/cone block.
`ifndef RAY_CONE_INTERSECTION_MACROS_SVH
`define RAY_CONE_INTERSECTION_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define RCI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define RCI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rci_pkg.sv]
// Package with the request/result types and register indexes of the ray/cone block.
`default_nettype none

package rci_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic               hit_found;
        logic signed [31:0] hit_distance;
        logic               far_root;
    } result_t;

    // Side data carried alongside the square-root stages.
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] bh;
        logic signed [31:0] oz;
        logic signed [31:0] dz;
        logic               nohit;
    } sq_side_t;

    // Side data carried alongside the divider stages.
    typedef struct packed {
        logic signed [31:0] oz;
        logic signed [31:0] dz;
        logic [31:0]        md;
        logic               nohit;
        logic               aneg;
        logic               n1neg;
        logic               n2neg;
        logic               ovf1;
        logic               ovf2;
    } dv_side_t;

endpackage

`default_nettype wire

[rtl/ray_cone_intersection.sv]
// Top level of the ray versus uncapped cone intersection pipeline.
// The 32-stage root and divider pipelines make up most of the pipeline's depth.
// Throughput: one request per cycle while busy is low; the receiver cannot stall the pipeline.
// A configuration write holds busy high while an iterative divider forms the cone slope;
// requests are refused during that time.
// Reset (rst_n, asynchronous) empties the pipeline and loads radius and height of 1.0.
`default_nettype none

module ray_cone_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire rci_pkg::ray_t                 ray,
    output logic                               done,
    output rci_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [rci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rci_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rci_pkg::*;

    // Stage numbering: 1 capture, 2..7 products, 8 coefficients, 9..10 discriminant,
    // 11..42 square root, 43..44 root numerators, 45..76 division, 77 root ordering, 78..79 height test.
    localparam int SQ_N = 32;
    localparam int DV_N = 32;
    localparam int LAT = 10 + SQ_N + 2 + DV_N + 3;

    localparam int DVW = CFG_DATA_W + FRAC_BITS;
    localparam int CW = $clog2(DVW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    localparam logic signed [65:0] MAXV = 66'sd2147483647;
    localparam logic signed [65:0] MINV = -66'sd2147483648;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > MAXV) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < MINV) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Fixed-point rescale of a raw product: floor divide by 2^F, then clamp.
    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        return sat32(66'(s));
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers and slope unit. The ratio r/h comes from
    // a restoring divider, one quotient bit per cycle; its square,
    // rescaled and clamped, is the constant k used by every ray.
    // ---------------------------------------------------------------
    logic [30:0]     radius_reg;
    logic [30:0]     height_reg;
    logic [30:0]     k_reg;
    logic [30:0]     k_next;
    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [DVW-1:0]  dq_reg;
    logic [DVW-1:0]  dq_next;
    logic [31:0]     crem_reg;
    logic [31:0]     crem_next;
    logic [61:0]     prod_reg;
    logic [61:0]     prod_next;
    logic [31:0]     crem_sh;
    logic [30:0]     q_sat;
    logic [61:0]     k_wide;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        dq_next = dq_reg;
        crem_next = crem_reg;
        prod_next = prod_reg;
        k_next = k_reg;
        crem_sh = {crem_reg[30:0], dq_reg[DVW-1]};
        q_sat = (|dq_reg[DVW-1:31]) ? MAX31 : dq_reg[30:0];
        k_wide = prod_reg >> FRAC_BITS;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOAD:
            begin
                dq_next = {radius_reg, FRAC_BITS'(0)};
                crem_next = '0;
                cnt_next = CW'(DVW - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (crem_sh >= {1'b0, height_reg}) begin
                    crem_next = crem_sh - {1'b0, height_reg};
                    dq_next = {dq_reg[DVW-2:0], 1'b1};
                end else begin
                    crem_next = crem_sh;
                    dq_next = {dq_reg[DVW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = q_sat * q_sat;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                k_next = (|k_wide[61:31]) ? MAX31 : k_wide[30:0];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Any write restarts the slope computation with the new values.
        if (cfg_we) begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radius_reg <= 31'd65536;
            height_reg <= 31'd65536;
            k_reg <= 31'(1) << FRAC_BITS;
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            if (cfg_we && cfg_index == CFG_RADIUS) begin
                radius_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_HEIGHT) begin
                height_reg <= cfg_data;
            end
            k_reg <= k_next;
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg <= dq_next;
        crem_reg <= crem_next;
        prod_reg <= prod_next;
    end

    assign busy = (state_reg != ST_IDLE);

    // Valid bits travel in one shift line beside the data.
    logic [LAT:1] vld_reg;
    logic [LAT:1] vld_next;
    logic         accept;

    assign accept = start && !busy;
    assign vld_next = {vld_reg[LAT-1:1], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------
    // Stages 1 to 8: the quadratic's coefficients a, half b and c.
    // Each multiplier is followed by a register before its rescale.
    // ---------------------------------------------------------------
    ray_t               s1_reg;
    logic signed [63:0] p_xx_reg, p_yy_reg, p_zz_reg, p_xo_reg, p_yo_reg, p_ox_reg, p_oy_reg;
    logic signed [31:0] s2_hz_reg, s2_oz_reg, s2_dz_reg;
    logic signed [31:0] hz_next;
    logic signed [31:0] m_xx_reg, m_yy_reg, m_zz_reg, m_xo_reg, m_yo_reg, m_ox_reg, m_oy_reg;
    logic signed [31:0] s3_hz_reg, s3_oz_reg, s3_dz_reg;
    logic signed [31:0] k_s;
    logic signed [63:0] p_zk_reg, p_hk_reg;
    logic signed [31:0] s4_xx_reg, s4_yy_reg, s4_xo_reg, s4_yo_reg, s4_ox_reg, s4_oy_reg;
    logic signed [31:0] s4_hz_reg, s4_oz_reg, s4_dz_reg;
    logic signed [31:0] m_zk_reg, m_hk_reg;
    logic signed [31:0] s5_xx_reg, s5_yy_reg, s5_xo_reg, s5_yo_reg, s5_ox_reg, s5_oy_reg;
    logic signed [31:0] s5_hz_reg, s5_oz_reg, s5_dz_reg;
    logic signed [63:0] p_dh_reg, p_hh_reg;
    logic signed [31:0] s6_xx_reg, s6_yy_reg, s6_xo_reg, s6_yo_reg, s6_ox_reg, s6_oy_reg;
    logic signed [31:0] s6_zk_reg, s6_oz_reg, s6_dz_reg;
    logic signed [31:0] m_dh_reg, m_hh_reg;
    logic signed [31:0] s7_xx_reg, s7_yy_reg, s7_xo_reg, s7_yo_reg, s7_ox_reg, s7_oy_reg;
    logic signed [31:0] s7_zk_reg, s7_oz_reg, s7_dz_reg;
    logic signed [31:0] a_next, bh_next, c_next;
    logic signed [31:0] s8_a_reg, s8_bh_reg, s8_c_reg, s8_oz_reg, s8_dz_reg;

    assign k_s = $signed({1'b0, k_reg});
    assign hz_next = sat32(66'($signed({1'b0, height_reg})) - 66'(s1_reg.origin_z));
    assign a_next = sat32(66'(s7_xx_reg) + 66'(s7_yy_reg) - 66'(s7_zk_reg));
    assign bh_next = sat32(66'(s7_xo_reg) + 66'(s7_yo_reg) + 66'(m_dh_reg));
    assign c_next = sat32(66'(s7_ox_reg) + 66'(s7_oy_reg) - 66'(m_hh_reg));

    always_ff @(posedge clk)
    begin
        s1_reg <= ray;

        p_xx_reg <= s1_reg.dir_x * s1_reg.dir_x;
        p_yy_reg <= s1_reg.dir_y * s1_reg.dir_y;
        p_zz_reg <= s1_reg.dir_z * s1_reg.dir_z;
        p_xo_reg <= s1_reg.dir_x * s1_reg.origin_x;
        p_yo_reg <= s1_reg.dir_y * s1_reg.origin_y;
        p_ox_reg <= s1_reg.origin_x * s1_reg.origin_x;
        p_oy_reg <= s1_reg.origin_y * s1_reg.origin_y;
        s2_hz_reg <= hz_next;
        s2_oz_reg <= s1_reg.origin_z;
        s2_dz_reg <= s1_reg.dir_z;

        m_xx_reg <= mulq(p_xx_reg);
        m_yy_reg <= mulq(p_yy_reg);
        m_zz_reg <= mulq(p_zz_reg);
        m_xo_reg <= mulq(p_xo_reg);
        m_yo_reg <= mulq(p_yo_reg);
        m_ox_reg <= mulq(p_ox_reg);
        m_oy_reg <= mulq(p_oy_reg);
        s3_hz_reg <= s2_hz_reg;
        s3_oz_reg <= s2_oz_reg;
        s3_dz_reg <= s2_dz_reg;

        p_zk_reg <= m_zz_reg * k_s;
        p_hk_reg <= s3_hz_reg * k_s;
        s4_xx_reg <= m_xx_reg;
        s4_yy_reg <= m_yy_reg;
        s4_xo_reg <= m_xo_reg;
        s4_yo_reg <= m_yo_reg;
        s4_ox_reg <= m_ox_reg;
        s4_oy_reg <= m_oy_reg;
        s4_hz_reg <= s3_hz_reg;
        s4_oz_reg <= s3_oz_reg;
        s4_dz_reg <= s3_dz_reg;

        m_zk_reg <= mulq(p_zk_reg);
        m_hk_reg <= mulq(p_hk_reg);
        s5_xx_reg <= s4_xx_reg;
        s5_yy_reg <= s4_yy_reg;
        s5_xo_reg <= s4_xo_reg;
        s5_yo_reg <= s4_yo_reg;
        s5_ox_reg <= s4_ox_reg;
        s5_oy_reg <= s4_oy_reg;
        s5_hz_reg <= s4_hz_reg;
        s5_oz_reg <= s4_oz_reg;
        s5_dz_reg <= s4_dz_reg;

        p_dh_reg <= s5_dz_reg * m_hk_reg;
        p_hh_reg <= s5_hz_reg * m_hk_reg;
        s6_xx_reg <= s5_xx_reg;
        s6_yy_reg <= s5_yy_reg;
        s6_xo_reg <= s5_xo_reg;
        s6_yo_reg <= s5_yo_reg;
        s6_ox_reg <= s5_ox_reg;
        s6_oy_reg <= s5_oy_reg;
        s6_zk_reg <= m_zk_reg;
        s6_oz_reg <= s5_oz_reg;
        s6_dz_reg <= s5_dz_reg;

        m_dh_reg <= mulq(p_dh_reg);
        m_hh_reg <= mulq(p_hh_reg);
        s7_xx_reg <= s6_xx_reg;
        s7_yy_reg <= s6_yy_reg;
        s7_xo_reg <= s6_xo_reg;
        s7_yo_reg <= s6_yo_reg;
        s7_ox_reg <= s6_ox_reg;
        s7_oy_reg <= s6_oy_reg;
        s7_zk_reg <= s6_zk_reg;
        s7_oz_reg <= s6_oz_reg;
        s7_dz_reg <= s6_dz_reg;

        s8_a_reg <= a_next;
        s8_bh_reg <= bh_next;
        s8_c_reg <= c_next;
        s8_oz_reg <= s7_oz_reg;
        s8_dz_reg <= s7_dz_reg;
    end

    // ---------------------------------------------------------------
    // Stages 9 and 10: the exact discriminant bh^2 - a*c. A zero leading
    // coefficient or a negative discriminant marks the ray as a miss.
    // ---------------------------------------------------------------
    logic signed [63:0] p_bb_reg, p_ac_reg;
    logic signed [31:0] s9_a_reg, s9_bh_reg, s9_oz_reg, s9_dz_reg;
    logic signed [63:0] disc_next;
    logic [63:0]        sq_rem_reg [0:SQ_N];
    logic [31:0]        sq_root_reg [0:SQ_N];
    sq_side_t           sq_side_reg [0:SQ_N];
    sq_side_t           sq_side_next;

    assign disc_next = p_bb_reg - p_ac_reg;

    always_comb
    begin
        sq_side_next.a = s9_a_reg;
        sq_side_next.bh = s9_bh_reg;
        sq_side_next.oz = s9_oz_reg;
        sq_side_next.dz = s9_dz_reg;
        sq_side_next.nohit = (s9_a_reg == 32'sd0) || disc_next[63];
    end

    always_ff @(posedge clk)
    begin
        p_bb_reg <= s8_bh_reg * s8_bh_reg;
        p_ac_reg <= s8_a_reg * s8_c_reg;
        s9_a_reg <= s8_a_reg;
        s9_bh_reg <= s8_bh_reg;
        s9_oz_reg <= s8_oz_reg;
        s9_dz_reg <= s8_dz_reg;

        sq_rem_reg[0] <= disc_next;
        sq_root_reg[0] <= '0;
        sq_side_reg[0] <= sq_side_next;
    end

    // ---------------------------------------------------------------
    // Stages 11 to 42: integer square root, one result bit per stage.
    // The remainder holds disc - root^2; setting bit b adds
    // root * 2^(b+1) + 4^b to the square.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int B = SQ_N - 1 - j;
        logic [63:0] term;
        logic        take;

        assign term = ({32'd0, sq_root_reg[j]} << (B + 1)) | (64'd1 << (2 * B));
        assign take = (sq_rem_reg[j] >= term);

        always_ff @(posedge clk)
        begin
            sq_rem_reg[j+1] <= take ? (sq_rem_reg[j] - term) : sq_rem_reg[j];
            sq_root_reg[j+1] <= take ? (sq_root_reg[j] | (32'd1 << B)) : sq_root_reg[j];
            sq_side_reg[j+1] <= sq_side_reg[j];
        end
    end

    // ---------------------------------------------------------------
    // Stages 43 and 44: numerators -bh + s and -bh - s, their
    // magnitudes shifted up by the fraction width, and an early check
    // for quotients of 2^32 or more.
    // ---------------------------------------------------------------
    sq_side_t           s43_side_reg;
    logic signed [33:0] n1_reg, n2_reg;
    logic signed [33:0] nbh, sroot;
    logic [33:0]        mag1, mag2;
    logic [31:0]        md_next;
    logic [63:0]        mn1, mn2, md_top;
    logic [63:0]        dv_rem1_reg [0:DV_N];
    logic [63:0]        dv_rem2_reg [0:DV_N];
    logic [31:0]        dv_q1_reg [0:DV_N];
    logic [31:0]        dv_q2_reg [0:DV_N];
    dv_side_t           dv_side_reg [0:DV_N];
    dv_side_t           dv_side_next;

    assign nbh = -34'(sq_side_reg[SQ_N].bh);
    assign sroot = $signed({2'b00, sq_root_reg[SQ_N]});
    assign mag1 = n1_reg[33] ? 34'(-n1_reg) : n1_reg;
    assign mag2 = n2_reg[33] ? 34'(-n2_reg) : n2_reg;
    assign md_next = s43_side_reg.a[31] ? 32'(-s43_side_reg.a) : s43_side_reg.a;
    assign mn1 = 64'(mag1) << FRAC_BITS;
    assign mn2 = 64'(mag2) << FRAC_BITS;
    assign md_top = {md_next, 32'd0};

    always_comb
    begin
        dv_side_next.oz = s43_side_reg.oz;
        dv_side_next.dz = s43_side_reg.dz;
        dv_side_next.md = md_next;
        dv_side_next.nohit = s43_side_reg.nohit;
        dv_side_next.aneg = s43_side_reg.a[31];
        dv_side_next.n1neg = n1_reg[33];
        dv_side_next.n2neg = n2_reg[33];
        dv_side_next.ovf1 = (mn1 >= md_top);
        dv_side_next.ovf2 = (mn2 >= md_top);
    end

    always_ff @(posedge clk)
    begin
        n1_reg <= nbh + sroot;
        n2_reg <= nbh - sroot;
        s43_side_reg <= sq_side_reg[SQ_N];

        dv_rem1_reg[0] <= mn1;
        dv_rem2_reg[0] <= mn2;
        dv_q1_reg[0] <= '0;
        dv_q2_reg[0] <= '0;
        dv_side_reg[0] <= dv_side_next;
    end

    // ---------------------------------------------------------------
    // Stages 45 to 76: two restoring dividers side by side, one quotient
    // bit per stage, for the magnitudes of both roots.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < DV_N; j++) begin : g_div
        localparam int B = DV_N - 1 - j;
        logic [63:0] term;
        logic        take1;
        logic        take2;

        assign term = {32'd0, dv_side_reg[j].md} << B;
        assign take1 = (dv_rem1_reg[j] >= term);
        assign take2 = (dv_rem2_reg[j] >= term);

        always_ff @(posedge clk)
        begin
            dv_rem1_reg[j+1] <= take1 ? (dv_rem1_reg[j] - term) : dv_rem1_reg[j];
            dv_rem2_reg[j+1] <= take2 ? (dv_rem2_reg[j] - term) : dv_rem2_reg[j];
            dv_q1_reg[j+1] <= take1 ? (dv_q1_reg[j] | (32'd1 << B)) : dv_q1_reg[j];
            dv_q2_reg[j+1] <= take2 ? (dv_q2_reg[j] | (32'd1 << B)) : dv_q2_reg[j];
            dv_side_reg[j+1] <= dv_side_reg[j];
        end
    end

    // ---------------------------------------------------------------
    // Stage 77: signed roots, range check and ordering. When only one
    // root fits 32 bits, the sign of the other one decides whether the
    // fitting root is the nearer or the farther.
    // ---------------------------------------------------------------
    dv_side_t           dv_end;
    logic               neg1, neg2, fail1, fail2;
    logic signed [31:0] r1, r2;
    logic signed [31:0] t_near_next, t_far_next;
    logic               ok_near_next, ok_far_next;
    logic               big_pos;

    assign dv_end = dv_side_reg[DV_N];
    assign neg1 = dv_end.n1neg != dv_end.aneg;
    assign neg2 = dv_end.n2neg != dv_end.aneg;
    assign fail1 = dv_end.ovf1 || (dv_q1_reg[DV_N] > 32'h8000_0000)
                   || (dv_q1_reg[DV_N] == 32'h8000_0000 && !neg1);
    assign fail2 = dv_end.ovf2 || (dv_q2_reg[DV_N] > 32'h8000_0000)
                   || (dv_q2_reg[DV_N] == 32'h8000_0000 && !neg2);
    assign r1 = neg1 ? 32'(-dv_q1_reg[DV_N]) : dv_q1_reg[DV_N];
    assign r2 = neg2 ? 32'(-dv_q2_reg[DV_N]) : dv_q2_reg[DV_N];
    assign big_pos = (fail1 ? dv_end.n1neg : dv_end.n2neg) == dv_end.aneg;

    always_comb
    begin
        t_near_next = r1;
        t_far_next = r2;
        ok_near_next = !fail1;
        ok_far_next = !fail2;
        if (!fail1 && !fail2 && (r1 > r2)) begin
            t_near_next = r2;
            t_far_next = r1;
        end else if (fail1 != fail2) begin
            if (big_pos) begin
                t_near_next = fail1 ? r2 : r1;
                ok_near_next = 1'b1;
                ok_far_next = 1'b0;
            end else begin
                t_far_next = fail1 ? r2 : r1;
                ok_near_next = 1'b0;
                ok_far_next = 1'b1;
            end
        end
    end

    logic signed [31:0] s77_tn_reg, s77_tf_reg, s77_oz_reg, s77_dz_reg;
    logic               s77_okn_reg, s77_okf_reg;

    always_ff @(posedge clk)
    begin
        s77_tn_reg <= t_near_next;
        s77_tf_reg <= t_far_next;
        s77_okn_reg <= ok_near_next && !dv_end.nohit;
        s77_okf_reg <= ok_far_next && !dv_end.nohit;
        s77_oz_reg <= dv_end.oz;
        s77_dz_reg <= dv_end.dz;
    end

    // ---------------------------------------------------------------
    // Stages 78 and 79: hit heights z = Oz + floor(t * Dz / 2^F), the
    // test 0 <= z <= h, and the choice of the reported root.
    // ---------------------------------------------------------------
    logic signed [63:0] p_zn_reg, p_zf_reg;
    logic signed [31:0] s78_tn_reg, s78_tf_reg, s78_oz_reg;
    logic               s78_okn_reg, s78_okf_reg;
    logic signed [65:0] zn, zf, h_s;
    logic               in_near, in_far;
    result_t            result_next;
    result_t            result_reg;

    assign h_s = 66'($signed({1'b0, height_reg}));
    assign zn = 66'(s78_oz_reg) + 66'(p_zn_reg >>> FRAC_BITS);
    assign zf = 66'(s78_oz_reg) + 66'(p_zf_reg >>> FRAC_BITS);
    assign in_near = s78_okn_reg && !zn[65] && (zn <= h_s);
    assign in_far = s78_okf_reg && !zf[65] && (zf <= h_s);

    always_comb
    begin
        result_next = '0;
        priority if (in_near) begin
            result_next.hit_found = 1'b1;
            result_next.hit_distance = s78_tn_reg;
        end else if (in_far) begin
            result_next.hit_found = 1'b1;
            result_next.hit_distance = s78_tf_reg;
            result_next.far_root = 1'b1;
        end else begin
            // A miss reports every field as zero.
            result_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_zn_reg <= s77_tn_reg * s77_dz_reg;
        p_zf_reg <= s77_tf_reg * s77_dz_reg;
        s78_tn_reg <= s77_tn_reg;
        s78_tf_reg <= s77_tf_reg;
        s78_oz_reg <= s77_oz_reg;
        s78_okn_reg <= s77_okn_reg;
        s78_okf_reg <= s77_okf_reg;
        result_reg <= result_next;
    end

    assign done = vld_reg[LAT];
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/rci_checker.sv]
// Port-level checker for the ray/cone block, bound to its top level.
`default_nettype none
`include "ray_cone_intersection_macros.svh"

module rci_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       busy,
    input wire logic       done,
    input wire rci_pkg::result_t result,
    input wire logic       cfg_we
);
    import rci_pkg::*;

    // A miss reports all zero fields.
    `RCI_ASSERT_IMP(a_miss_zero, done && !result.hit_found, (result.hit_distance == 32'sd0) && !result.far_root, "miss result carries nonzero fields")

    // The farther root is only flagged on a hit.
    `RCI_ASSERT_IMP(a_far_hit, done && result.far_root, result.hit_found, "far root flagged without a hit")

    // A register write starts the slope computation.
    `RCI_ASSERT_NXT(a_cfg_busy, cfg_we, busy, "busy not raised after a register write")

    // Busy only rises in answer to a register write.
    `RCI_ASSERT_IMP(a_busy_src, $rose(busy), $past(cfg_we), "busy rose without a register write")

endmodule

bind ray_cone_intersection rci_checker u_rci_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result),
    .cfg_we (cfg_we)
);

`default_nettype wire
